// File: rtl/core/pipwh_pkg.sv
`default_nettype none

package pipwh_pkg;

    localparam int MAX_OUTER_VERTICES_DEF  = 32;
    localparam int MAX_ISLAND_VERTICES_DEF = 32;
    localparam int MIN_RING_VERTICES       = 3;
    localparam int COORD_W                 = 32;
    localparam int VERTEX_W                = 2 * COORD_W;
    localparam int DIFF_W                  = COORD_W + 1;
    localparam int PROD_W                  = 2 * DIFF_W;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_OUTER  = 2'd1;
    localparam logic [1:0] CMD_ISLAND = 2'd2;
    localparam logic [1:0] CMD_QUERY  = 2'd3;

    typedef struct packed {
        logic [1:0]                 command;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
        logic signed [COORD_W-1:0]  coord_z;
    } req_t;

    typedef struct packed {
        logic inside_res;
        logic load_overflow;
    } res_t;

    typedef struct packed {
        logic valid;
        logic prime;
        logic island;
    } walk_t;

    typedef struct packed {
        logic  req_load;
        logic  outer_we;
        logic  outer_re;
        logic  island_we;
        logic  island_re;
        walk_t walk;
        logic  par_clr;
        logic  out_load;
        logic  out_query;
        logic  out_ovf;
    } dp_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/pipwh_ram.sv
`default_nettype none

module pipwh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic                  re,
    input  wire logic [AW-1:0]         addr,
    input  wire logic [WIDTH-1:0]      wdata,
    output logic      [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/pipwh_ctrl.sv
`default_nettype none

module pipwh_ctrl #(
    parameter int MAX_OUTER_VERTICES  = pipwh_pkg::MAX_OUTER_VERTICES_DEF,
    parameter int MAX_ISLAND_VERTICES = pipwh_pkg::MAX_ISLAND_VERTICES_DEF,
    localparam int OAW = (MAX_OUTER_VERTICES > 1) ? $clog2(MAX_OUTER_VERTICES) : 1,
    localparam int IAW = (MAX_ISLAND_VERTICES > 1) ? $clog2(MAX_ISLAND_VERTICES) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire logic [1:0]           req_command,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output pipwh_pkg::dp_cmd_t        cmd,
    output logic      [OAW-1:0]       outer_addr,
    output logic      [IAW-1:0]       island_addr
);

    localparam int OCW = $clog2(MAX_OUTER_VERTICES + 1);
    localparam int ICW = $clog2(MAX_ISLAND_VERTICES + 1);
    localparam int WCW = (OCW > ICW) ? OCW : ICW;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_OUTER  = 3'd2;
    localparam logic [2:0] S_ISLAND = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]     state_reg, state_next;
    logic [1:0]     command_reg, command_next;
    logic [OCW-1:0] outer_count_reg, outer_count_next;
    logic [ICW-1:0] island_count_reg, island_count_next;
    logic [WCW-1:0] walk_cnt_reg, walk_cnt_next;
    logic [1:0]     drain_reg, drain_next;
    logic           ovf_reg, ovf_next;
    logic           qok_reg, qok_next;
    logic           res_valid_reg, res_valid_next;

    logic [WCW-1:0] outer_len;
    logic [WCW-1:0] island_len;
    logic [WCW-1:0] walk_outer_addr;
    logic [WCW-1:0] walk_island_addr;

    assign outer_len  = WCW'(outer_count_reg);
    assign island_len = WCW'(island_count_reg);
    assign walk_outer_addr  = (walk_cnt_reg == '0) ? outer_len - WCW'(1)
                                                   : walk_cnt_reg - WCW'(1);
    assign walk_island_addr = (walk_cnt_reg == '0) ? island_len - WCW'(1)
                                                   : walk_cnt_reg - WCW'(1);

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;

    always_comb
    begin
        state_next        = state_reg;
        command_next      = command_reg;
        outer_count_next  = outer_count_reg;
        island_count_next = island_count_reg;
        walk_cnt_next     = walk_cnt_reg;
        drain_next        = drain_reg;
        ovf_next          = ovf_reg;
        qok_next          = qok_reg;
        res_valid_next    = res_valid_reg & ~res_ready;
        cmd               = '0;
        outer_addr        = outer_count_reg[OAW-1:0];
        island_addr       = island_count_reg[IAW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.req_load = 1'b1;
                    command_next = req_command;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ovf_next      = 1'b0;
                qok_next      = 1'b0;
                walk_cnt_next = '0;
                state_next    = S_DONE;
                case (command_reg)
                    pipwh_pkg::CMD_CLEAR:
                    begin
                        outer_count_next  = '0;
                        island_count_next = '0;
                    end
                    pipwh_pkg::CMD_OUTER:
                    begin
                        if (outer_count_reg == OCW'(MAX_OUTER_VERTICES))
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            cmd.outer_we     = 1'b1;
                            outer_count_next = outer_count_reg + OCW'(1);
                        end
                    end
                    pipwh_pkg::CMD_ISLAND:
                    begin
                        if (island_count_reg == ICW'(MAX_ISLAND_VERTICES))
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            cmd.island_we     = 1'b1;
                            island_count_next = island_count_reg + ICW'(1);
                        end
                    end
                    default:
                    begin
                        cmd.par_clr = 1'b1;
                        if (outer_count_reg >= OCW'(pipwh_pkg::MIN_RING_VERTICES))
                        begin
                            qok_next   = 1'b1;
                            state_next = S_OUTER;
                        end
                    end
                endcase
            end
            S_OUTER:
            begin
                cmd.outer_re     = 1'b1;
                cmd.walk.valid   = 1'b1;
                cmd.walk.prime   = (walk_cnt_reg == '0);
                cmd.walk.island  = 1'b0;
                outer_addr       = walk_outer_addr[OAW-1:0];
                if (walk_cnt_reg == outer_len)
                begin
                    walk_cnt_next = '0;
                    drain_next    = '0;
                    state_next    = (island_count_reg != '0) ? S_ISLAND : S_DRAIN;
                end
                else
                begin
                    walk_cnt_next = walk_cnt_reg + WCW'(1);
                end
            end
            S_ISLAND:
            begin
                cmd.island_re    = 1'b1;
                cmd.walk.valid   = 1'b1;
                cmd.walk.prime   = (walk_cnt_reg == '0);
                cmd.walk.island  = 1'b1;
                island_addr      = walk_island_addr[IAW-1:0];
                if (walk_cnt_reg == island_len)
                begin
                    walk_cnt_next = '0;
                    drain_next    = '0;
                    state_next    = S_DRAIN;
                end
                else
                begin
                    walk_cnt_next = walk_cnt_reg + WCW'(1);
                end
            end
            S_DRAIN:
            begin
                if (drain_reg == 2'd2)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    drain_next = drain_reg + 2'd1;
                end
            end
            S_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_query  = qok_reg;
                    cmd.out_ovf    = ovf_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            command_reg      <= pipwh_pkg::CMD_CLEAR;
            outer_count_reg  <= '0;
            island_count_reg <= '0;
            walk_cnt_reg     <= '0;
            drain_reg        <= '0;
            ovf_reg          <= 1'b0;
            qok_reg          <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            command_reg      <= command_next;
            outer_count_reg  <= outer_count_next;
            island_count_reg <= island_count_next;
            walk_cnt_reg     <= walk_cnt_next;
            drain_reg        <= drain_next;
            ovf_reg          <= ovf_next;
            qok_reg          <= qok_next;
            res_valid_reg    <= res_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pipwh_dp.sv
`default_nettype none

module pipwh_dp #(
    parameter int MAX_OUTER_VERTICES  = pipwh_pkg::MAX_OUTER_VERTICES_DEF,
    parameter int MAX_ISLAND_VERTICES = pipwh_pkg::MAX_ISLAND_VERTICES_DEF,
    localparam int OAW = (MAX_OUTER_VERTICES > 1) ? $clog2(MAX_OUTER_VERTICES) : 1,
    localparam int IAW = (MAX_ISLAND_VERTICES > 1) ? $clog2(MAX_ISLAND_VERTICES) : 1
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire pipwh_pkg::dp_cmd_t                     cmd,
    input  wire logic [OAW-1:0]                         outer_addr,
    input  wire logic [IAW-1:0]                         island_addr,
    input  wire pipwh_pkg::req_t                        req,
    input  wire logic                                   cfg_we,
    input  wire logic [pipwh_pkg::COORD_W-1:0]          cfg_data,
    output pipwh_pkg::res_t                             res
);

    localparam int CW = pipwh_pkg::COORD_W;
    localparam int VW = pipwh_pkg::VERTEX_W;
    localparam int DW = pipwh_pkg::DIFF_W;
    localparam int PW = pipwh_pkg::PROD_W;

    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [CW-1:0] height_reg;
    logic [VW-1:0]        outer_rdata, island_rdata;
    logic [VW-1:0]        prev_reg;
    logic [VW-1:0]        cur;

    pipwh_pkg::walk_t     tag1_reg;
    logic                 v2_reg, isl2_reg, dpos2_reg;
    logic signed [DW-1:0] ma_reg, mb_reg, mc_reg, md_reg;
    logic                 v3_reg, isl3_reg, dpos3_reg;
    logic signed [PW-1:0] lhs_reg, rhs_reg;
    logic                 outer_par_reg, island_par_reg;
    pipwh_pkg::res_t      res_reg;

    logic signed [CW-1:0] ax, ay, bx, by;
    logic                 straddle;
    logic                 crossed;

    pipwh_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_OUTER_VERTICES)
    ) u_outer_ram (
        .clk   (clk),
        .we    (cmd.outer_we),
        .re    (cmd.outer_re),
        .addr  (outer_addr),
        .wdata ({y_reg, x_reg}),
        .rdata (outer_rdata)
    );

    pipwh_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_ISLAND_VERTICES)
    ) u_island_ram (
        .clk   (clk),
        .we    (cmd.island_we),
        .re    (cmd.island_re),
        .addr  (island_addr),
        .wdata ({y_reg, x_reg}),
        .rdata (island_rdata)
    );

    assign cur = tag1_reg.island ? island_rdata : outer_rdata;
    assign ax  = $signed(cur[CW-1:0]);
    assign ay  = $signed(cur[VW-1:CW]);
    assign bx  = $signed(prev_reg[CW-1:0]);
    assign by  = $signed(prev_reg[VW-1:CW]);
    assign straddle = (ay > y_reg) != (by > y_reg);
    assign crossed = dpos3_reg ? (lhs_reg < rhs_reg) : (rhs_reg < lhs_reg);

    // hold the request and the detection height
    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            x_reg <= req.coord_x;
            y_reg <= req.coord_y;
            z_reg <= req.coord_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= '0;
        end
        else if (cfg_we)
        begin
            height_reg <= cfg_data;
        end
    end

    // edge pipeline: differences, products, compare
    always_ff @(posedge clk)
    begin
        if (tag1_reg.valid)
        begin
            prev_reg <= cur;
        end
        isl2_reg  <= tag1_reg.island;
        dpos2_reg <= by > ay;
        ma_reg    <= $signed({x_reg[CW-1], x_reg}) - $signed({ax[CW-1], ax});
        mb_reg    <= $signed({by[CW-1], by}) - $signed({ay[CW-1], ay});
        mc_reg    <= $signed({bx[CW-1], bx}) - $signed({ax[CW-1], ax});
        md_reg    <= $signed({y_reg[CW-1], y_reg}) - $signed({ay[CW-1], ay});
        isl3_reg  <= isl2_reg;
        dpos3_reg <= dpos2_reg;
        lhs_reg   <= ma_reg * mb_reg;
        rhs_reg   <= mc_reg * md_reg;
        if (cmd.out_load)
        begin
            res_reg.inside_res    <= cmd.out_query & (z_reg <= height_reg)
                                     & outer_par_reg & ~island_par_reg;
            res_reg.load_overflow <= cmd.out_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg       <= '0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            outer_par_reg  <= 1'b0;
            island_par_reg <= 1'b0;
        end
        else
        begin
            tag1_reg <= cmd.walk;
            v2_reg   <= tag1_reg.valid & ~tag1_reg.prime & straddle;
            v3_reg   <= v2_reg;
            if (cmd.par_clr)
            begin
                outer_par_reg  <= 1'b0;
                island_par_reg <= 1'b0;
            end
            else if (v3_reg && crossed)
            begin
                if (isl3_reg)
                begin
                    island_par_reg <= ~island_par_reg;
                end
                else
                begin
                    outer_par_reg <= ~outer_par_reg;
                end
            end
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// File: rtl/core/point_in_polygon_with_hole.sv
// Sequencing: loads and clear return a result without any ring walk; a query walks
// the outer ring, then the island ring unless it is empty, and skips the walk
// when the outer ring has fewer than 3 vertices.
// Throughput: one request at a time, set by the single-port vertex RAM walk of one
// edge per cycle through a 3-stage difference/multiply/compare pipeline.
// Reset: rst_n clears both ring counts, detection height and the handshake state.
`default_nettype none

module point_in_polygon_with_hole #(
    parameter int MAX_OUTER_VERTICES  = pipwh_pkg::MAX_OUTER_VERTICES_DEF,
    parameter int MAX_ISLAND_VERTICES = pipwh_pkg::MAX_ISLAND_VERTICES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire pipwh_pkg::req_t               req,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output pipwh_pkg::res_t                    res,
    input  wire logic                          cfg_we,
    input  wire logic [pipwh_pkg::COORD_W-1:0] cfg_data
);

    localparam int OAW = (MAX_OUTER_VERTICES > 1) ? $clog2(MAX_OUTER_VERTICES) : 1;
    localparam int IAW = (MAX_ISLAND_VERTICES > 1) ? $clog2(MAX_ISLAND_VERTICES) : 1;

    pipwh_pkg::dp_cmd_t cmd;
    logic [OAW-1:0]     outer_addr;
    logic [IAW-1:0]     island_addr;

    pipwh_ctrl #(
        .MAX_OUTER_VERTICES  (MAX_OUTER_VERTICES),
        .MAX_ISLAND_VERTICES (MAX_ISLAND_VERTICES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_command (req.command),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .cmd         (cmd),
        .outer_addr  (outer_addr),
        .island_addr (island_addr)
    );

    pipwh_dp #(
        .MAX_OUTER_VERTICES  (MAX_OUTER_VERTICES),
        .MAX_ISLAND_VERTICES (MAX_ISLAND_VERTICES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .outer_addr  (outer_addr),
        .island_addr (island_addr),
        .req         (req),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .res         (res)
    );

endmodule

`default_nettype wire
